>>> rtl/core/nrmcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmcv_pkg
// Shared constants and types of the normalized 3x3 convolution unit.
// ----------------------------------------------------------------------------
package nrmcv_pkg;

    localparam int NUM_TAPS     = 9;
    localparam int NUM_ROWS     = 3;
    localparam int NUM_COLS     = 3;
    localparam int LANE_BITS    = 8;
    localparam int ROW_BITS     = 24;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [ROW_BITS-1:0] ROW_RESET = 24'h010101;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP_ROW    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIDDLE_ROW = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM_ROW = 2'd2;

    // advance strobes of the two merge stages
    typedef struct packed {
        logic adv_row;
        logic adv_total;
    } merge_ctl_t;

endpackage

>>> rtl/core/nrmcv_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmcv_lane
// One multiply lane: registers pixel times weight for one tap.
// ----------------------------------------------------------------------------
module nrmcv_lane #(
    parameter int PIXEL_BITS  = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                              clk,
    input  logic                              adv,
    input  logic [PIXEL_BITS-1:0]             pixel,
    input  logic [WEIGHT_BITS-1:0]            weight,
    output logic [PIXEL_BITS+WEIGHT_BITS-1:0] product
);

    localparam int PROD_W = PIXEL_BITS + WEIGHT_BITS;

    logic [PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            product_reg <= PROD_W'(pixel) * PROD_W'(weight);
        end
    end

    assign product = product_reg;

endmodule

>>> rtl/core/nrmcv_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmcv_merge
// Two-stage adder tree: row sums of the lane products and weights, then totals.
// ----------------------------------------------------------------------------
module nrmcv_merge #(
    parameter int PIXEL_BITS  = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                                clk,
    input  nrmcv_pkg::merge_ctl_t               ctl,
    input  logic [PIXEL_BITS+WEIGHT_BITS-1:0]   prod   [nrmcv_pkg::NUM_TAPS],
    input  logic [WEIGHT_BITS-1:0]              weight [nrmcv_pkg::NUM_TAPS],
    output logic [PIXEL_BITS+WEIGHT_BITS+3:0]   acc,
    output logic [WEIGHT_BITS+3:0]              wsum
);

    localparam int PROD_W = PIXEL_BITS + WEIGHT_BITS;
    localparam int ROW_W  = PROD_W + 2;
    localparam int ACC_W  = PROD_W + 4;
    localparam int WROW_W = WEIGHT_BITS + 2;
    localparam int WSUM_W = WEIGHT_BITS + 4;

    logic [ROW_W-1:0]  row_sum_reg  [nrmcv_pkg::NUM_ROWS];
    logic [WROW_W-1:0] wrow_sum_reg [nrmcv_pkg::NUM_ROWS];
    logic [ACC_W-1:0]  acc_reg;
    logic [WSUM_W-1:0] wsum_reg;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < nrmcv_pkg::NUM_ROWS; r++)
        begin
            if (ctl.adv_row)
            begin
                row_sum_reg[r]  <= ROW_W'(prod[3*r]) + ROW_W'(prod[3*r+1])
                                 + ROW_W'(prod[3*r+2]);
                wrow_sum_reg[r] <= WROW_W'(weight[3*r]) + WROW_W'(weight[3*r+1])
                                 + WROW_W'(weight[3*r+2]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv_total)
        begin
            acc_reg  <= ACC_W'(row_sum_reg[0]) + ACC_W'(row_sum_reg[1])
                      + ACC_W'(row_sum_reg[2]);
            wsum_reg <= WSUM_W'(wrow_sum_reg[0]) + WSUM_W'(wrow_sum_reg[1])
                      + WSUM_W'(wrow_sum_reg[2]);
        end
    end

    assign acc  = acc_reg;
    assign wsum = wsum_reg;

endmodule

>>> rtl/core/nrmcv_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmcv_div_stage
// One restoring-division step: resolves quotient bit BIT and registers it.
// ----------------------------------------------------------------------------
module nrmcv_div_stage #(
    parameter int PIXEL_BITS = 8,
    parameter int ACC_W      = 20,
    parameter int WSUM_W     = 12,
    parameter int BIT        = 0
) (
    input  logic                  clk,
    input  logic                  adv,
    input  logic [ACC_W-1:0]      rem_in,
    input  logic [WSUM_W-1:0]     div_in,
    input  logic [PIXEL_BITS-1:0] quo_in,
    output logic [ACC_W-1:0]      rem_out,
    output logic [WSUM_W-1:0]     div_out,
    output logic [PIXEL_BITS-1:0] quo_out
);

    localparam int CMP_W = ACC_W + PIXEL_BITS;

    logic [CMP_W-1:0]      dshift;
    logic [CMP_W-1:0]      rem_ext;
    logic [CMP_W-1:0]      diff;
    logic                  take;
    logic [ACC_W-1:0]      rem_reg;
    logic [WSUM_W-1:0]     div_reg;
    logic [PIXEL_BITS-1:0] quo_reg;

    assign dshift  = CMP_W'(div_in) << BIT;
    assign rem_ext = CMP_W'(rem_in);
    assign diff    = rem_ext - dshift;
    assign take    = (rem_ext >= dshift);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= take ? ACC_W'(diff) : rem_in;
            quo_reg <= take ? (quo_in | (PIXEL_BITS'(1) << BIT)) : quo_in;
            div_reg <= div_in;
        end
    end

    assign rem_out = rem_reg;
    assign div_out = div_reg;
    assign quo_out = quo_reg;

endmodule

>>> rtl/core/normalized_3x3_convolution_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_3x3_convolution_unit
// Weighted 3x3 average: nine multiply lanes, an adder-tree merge and a
// pipelined divider that resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
// Pipeline: PIXEL_BITS + 3 register stages (11 by default).
// Throughput: one item per cycle while the output is not stalled; every stage
//   holds its own valid bit, so a stalled output only stops the stages behind it once they fill up.
// Reset: rst_n clears all valid bits and loads the box mask into all weights.
// ----------------------------------------------------------------------------
module normalized_3x3_convolution_unit #(
    parameter int PIXEL_BITS  = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [nrmcv_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [nrmcv_pkg::ROW_BITS-1:0]        cfg_data,
    // input window stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata from bit 0 up: pix_top_left, pix_top_mid, pix_top_right,
    // pix_mid_left, pix_center, pix_mid_right, pix_bot_left, pix_bot_mid,
    // pix_bot_right, zero fill
    input  logic [((9*PIXEL_BITS+7)/8)*8-1:0]     s_tdata,
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata from bit 0 up: filtered_pixel, zero fill
    output logic [((PIXEL_BITS+7)/8)*8-1:0]       m_tdata,
    // m_tuser: zero_weight_sum
    output logic                                  m_tuser
);

    localparam int NUM_TAPS = nrmcv_pkg::NUM_TAPS;
    localparam int OUT_W    = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int PROD_W   = PIXEL_BITS + WEIGHT_BITS;
    localparam int ACC_W    = PROD_W + 4;
    localparam int WSUM_W   = WEIGHT_BITS + 4;
    // stage 0: lanes, 1..2: merge, 3..: divider bits
    localparam int DIV_BASE = 3;
    localparam int NST      = DIV_BASE + PIXEL_BITS;

    // ------------------------------------------------------------------
    // Weight registers; a write to an index past the list is dropped.
    // ------------------------------------------------------------------
    logic [nrmcv_pkg::ROW_BITS-1:0] weight_row_reg [nrmcv_pkg::NUM_ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < nrmcv_pkg::NUM_ROWS; r++)
            begin
                weight_row_reg[r] <= nrmcv_pkg::ROW_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nrmcv_pkg::REG_TOP_ROW:    weight_row_reg[0] <= cfg_data;
                nrmcv_pkg::REG_MIDDLE_ROW: weight_row_reg[1] <= cfg_data;
                nrmcv_pkg::REG_BOTTOM_ROW: weight_row_reg[2] <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Each weight is the low WEIGHT_BITS of its byte lane, left in the low byte.
    logic [WEIGHT_BITS-1:0] weight [NUM_TAPS];
    logic [PIXEL_BITS-1:0]  pixel  [NUM_TAPS];

    genvar t;
    generate
        for (t = 0; t < NUM_TAPS; t++)
        begin : g_taps
            assign weight[t] = weight_row_reg[t / nrmcv_pkg::NUM_COLS]
                [(t % nrmcv_pkg::NUM_COLS) * nrmcv_pkg::LANE_BITS +: WEIGHT_BITS];
            assign pixel[t]  = s_tdata[t*PIXEL_BITS +: PIXEL_BITS];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Flow control: every stage has a valid bit and loads when it is empty
    // or its successor loads, so bubbles collapse behind a stalled output.
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] adv;

    assign adv[NST-1] = !vld_reg[NST-1] || m_tready;

    genvar s;
    generate
        for (s = 0; s < NST - 1; s++)
        begin : g_ready
            assign adv[s] = !vld_reg[s] || adv[s+1];
        end
    endgenerate

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];

    // ------------------------------------------------------------------
    // Multiply lanes, one per tap.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod [NUM_TAPS];

    generate
        for (t = 0; t < NUM_TAPS; t++)
        begin : g_lanes
            nrmcv_lane #(
                .PIXEL_BITS  (PIXEL_BITS),
                .WEIGHT_BITS (WEIGHT_BITS)
            ) u_lane (
                .clk     (clk),
                .adv     (adv[0]),
                .pixel   (pixel[t]),
                .weight  (weight[t]),
                .product (prod[t])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Merge: weighted sum and weight sum, the latter read from the registers.
    // User must hold weights steady while items are in flight (not enforced).
    // ------------------------------------------------------------------
    nrmcv_pkg::merge_ctl_t merge_ctl;
    logic [ACC_W-1:0]      acc;
    logic [WSUM_W-1:0]     wsum;

    assign merge_ctl.adv_row   = adv[1];
    assign merge_ctl.adv_total = adv[2];

    nrmcv_merge #(
        .PIXEL_BITS  (PIXEL_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_merge (
        .clk    (clk),
        .ctl    (merge_ctl),
        .prod   (prod),
        .weight (weight),
        .acc    (acc),
        .wsum   (wsum)
    );

    // ------------------------------------------------------------------
    // Divider: quotient bits from the top down. The weighted average never
    // exceeds the largest pixel, so PIXEL_BITS steps resolve it exactly.
    // ------------------------------------------------------------------
    logic [ACC_W-1:0]      rem_s [PIXEL_BITS+1];
    logic [WSUM_W-1:0]     div_s [PIXEL_BITS+1];
    logic [PIXEL_BITS-1:0] quo_s [PIXEL_BITS+1];

    assign rem_s[0] = acc;
    assign div_s[0] = wsum;
    assign quo_s[0] = '0;

    genvar k;
    generate
        for (k = 0; k < PIXEL_BITS; k++)
        begin : g_div
            nrmcv_div_stage #(
                .PIXEL_BITS (PIXEL_BITS),
                .ACC_W      (ACC_W),
                .WSUM_W     (WSUM_W),
                .BIT        (PIXEL_BITS - 1 - k)
            ) u_div (
                .clk     (clk),
                .adv     (adv[DIV_BASE + k]),
                .rem_in  (rem_s[k]),
                .div_in  (div_s[k]),
                .quo_in  (quo_s[k]),
                .rem_out (rem_s[k+1]),
                .div_out (div_s[k+1]),
                .quo_out (quo_s[k+1])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output: the last divider stage is the output register. A zero weight
    // sum would read as all ones from the divider, so force the pixel to 0.
    // ------------------------------------------------------------------
    logic zero_sum;

    assign zero_sum = (div_s[PIXEL_BITS] == '0);
    assign m_tvalid = vld_reg[NST-1];
    assign m_tuser  = zero_sum;
    assign m_tdata  = zero_sum ? '0 : OUT_W'(quo_s[PIXEL_BITS]);

`ifndef SYNTHESIS
    logic [WSUM_W-1:0] cfg_wsum;

    always_comb
    begin
        cfg_wsum = '0;
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            cfg_wsum = cfg_wsum + WSUM_W'(weight[i]);
        end
    end

    // an empty output stage means every stage behind it can load
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    // the zero flag carried through the pipe agrees with the live weights
    a_zero_flag_matches_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (cfg_wsum == '0)))
        else $error("zero weight flag disagrees with weight registers");

    // a stalled result keeps its stage and its payload
    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result lost or changed");
`endif

endmodule
